// ===== src/sga_pkg.sv =====
// Package for the stick arming gesture detector.
// Holds payload and state types, thresholds and register codes; no dependencies.
`timescale 1ns / 1ps

package sga_pkg;

  localparam int unsigned NumChan   = 4;
  localparam int unsigned PulseW    = 12;
  localparam int unsigned FlagW     = 2 * NumChan;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgIdxW   = 8;

  localparam logic [PulseW-1:0] PulseMin = 12'd900;
  localparam logic [PulseW-1:0] PulseMax = 12'd2000;
  localparam logic [CountW-1:0] CountSat = 8'd250;
  localparam logic [CountW-1:0] HoldTicks = 8'd100;

  localparam logic [PulseW-1:0] LowCheckRst  = 12'd1100;
  localparam logic [PulseW-1:0] HighCheckRst = 12'd1900;

  // Channel order inside the flag vector
  localparam int unsigned ChRoll  = 0;
  localparam int unsigned ChPitch = 1;
  localparam int unsigned ChYaw   = 2;
  localparam int unsigned ChThr   = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLowCheck  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgHighCheck = 8'd1;

  typedef struct packed {
    logic [PulseW-1:0] roll_raw;
    logic [PulseW-1:0] pitch_raw;
    logic [PulseW-1:0] yaw_raw;
    logic [PulseW-1:0] throttle_raw;
  } sga_in_t;

  typedef struct packed {
    logic             armed;
    logic             arm_event;
    logic             disarm_event;
    logic [FlagW-1:0] stick_flags;
  } sga_out_t;

  // Per-channel compare result
  typedef struct packed {
    logic in_range;
    logic low;
    logic high;
  } sga_lane_t;

  // Gesture state carried between items
  typedef struct packed {
    logic [FlagW-1:0]  flags;
    logic [CountW-1:0] count;
    logic              armed;
  } sga_state_t;

endpackage

// ===== src/sga_lane.sv =====
// One channel compare lane: range check and low/high threshold flags.
// Depends on sga_pkg.
`timescale 1ns / 1ps

module sga_lane (
  input  logic [sga_pkg::PulseW-1:0] raw_i,
  input  logic [sga_pkg::PulseW-1:0] low_check_i,
  input  logic [sga_pkg::PulseW-1:0] high_check_i,
  output sga_pkg::sga_lane_t         lane_o
);
  import sga_pkg::*;

  // Valid pulse window and thresholds
  always_comb begin
    lane_o.in_range = (raw_i >= PulseMin) && (raw_i <= PulseMax);
    lane_o.low      = raw_i < low_check_i;
    lane_o.high     = raw_i > high_check_i;
  end

endmodule

// ===== src/sga_merge.sv =====
// Merges the lane results with the held state: scan cutoff, hold counter
// and arm/disarm decision. Depends on sga_pkg.
`timescale 1ns / 1ps

module sga_merge (
  input  sga_pkg::sga_lane_t [sga_pkg::NumChan-1:0] lanes_i,
  input  sga_pkg::sga_state_t                       state_i,
  output sga_pkg::sga_state_t                       state_o,
  output sga_pkg::sga_out_t                         result_o
);
  import sga_pkg::*;

  logic [NumChan-1:0] scan_ok;
  logic [FlagW-1:0]   flags_scan;
  logic [CountW-1:0]  count_run;
  logic [FlagW-1:0]   flags_run;
  logic               hold_hit;
  logic               thr_low;
  logic               arm_ev;
  logic               disarm_ev;

  // Scan stops at the first out-of-range channel; it and later channels keep their held flags
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      if (c == 0) begin
        scan_ok[c] = lanes_i[c].in_range;
      end else begin
        scan_ok[c] = scan_ok[c-1] && lanes_i[c].in_range;
      end
      if (scan_ok[c]) begin
        flags_scan[2*c]   = lanes_i[c].low;
        flags_scan[2*c+1] = lanes_i[c].high;
      end else begin
        flags_scan[2*c]   = state_i.flags[2*c];
        flags_scan[2*c+1] = state_i.flags[2*c+1];
      end
    end
  end

  // Hold counter, saturating; clears with the flags when nothing is held
  always_comb begin
    if (flags_scan != '0) begin
      flags_run = flags_scan;
      count_run = (state_i.count < CountSat) ? state_i.count + 8'd1 : state_i.count;
    end else begin
      flags_run = '0;
      count_run = '0;
    end
  end

  // Gesture check at the hold point
  always_comb begin
    hold_hit  = count_run == HoldTicks;
    thr_low   = flags_run[2*ChThr];
    disarm_ev = hold_hit && state_i.armed && flags_run[2*ChYaw] && thr_low;
    arm_ev    = hold_hit && !state_i.armed && flags_run[2*ChYaw+1] && thr_low;

    state_o.armed = (state_i.armed && !disarm_ev) || arm_ev;
    state_o.flags = hold_hit ? '0 : flags_run;
    state_o.count = hold_hit ? '0 : count_run;

    result_o.armed        = state_o.armed;
    result_o.arm_event    = arm_ev;
    result_o.disarm_event = disarm_ev;
    result_o.stick_flags  = state_o.flags;
  end

endmodule

// ===== src/stick_gesture_arm_disarm.sv =====
// Top level of the stick arming gesture detector: config registers, four
// compare lanes, merge stage, state registers and output skid buffer.
// Depends on sga_pkg, sga_lane, sga_merge.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o | in_data_i (four pulses)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (arm, flags)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low: lanes and merge settle in the accept
// cycle, and state and result are registered at the accept edge.
// A two-entry output buffer (output register plus skid) lets items keep
// flowing while the output is stalled; in_stall_o rises only when both are full.
// Reset clears state, thresholds go to 1100 and 1900, no clearing pass.
// cfg_ready_o is always high.
`timescale 1ns / 1ps

module stick_gesture_arm_disarm (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sga_pkg::sga_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sga_pkg::sga_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sga_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sga_pkg::PulseW-1:0]   cfg_data_i
);
  import sga_pkg::*;

  logic [PulseW-1:0] low_check_q, high_check_q;
  sga_state_t        state_q, state_d;
  sga_out_t          result;
  sga_out_t          out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              in_accept, out_pop;

  logic [NumChan-1:0][PulseW-1:0] raw;
  sga_lane_t [NumChan-1:0]        lanes;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_check_q  <= LowCheckRst;
      high_check_q <= HighCheckRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgLowCheck:  low_check_q  <= cfg_data_i;
        CfgHighCheck: high_check_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Compare lanes
  assign raw[ChRoll]  = in_data_i.roll_raw;
  assign raw[ChPitch] = in_data_i.pitch_raw;
  assign raw[ChYaw]   = in_data_i.yaw_raw;
  assign raw[ChThr]   = in_data_i.throttle_raw;

  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    sga_lane u_lane (
      .raw_i        (raw[c]),
      .low_check_i  (low_check_q),
      .high_check_i (high_check_q),
      .lane_o       (lanes[c])
    );
  end

  // Merge stage
  sga_merge u_merge (
    .lanes_i  (lanes),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result)
  );

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_pop    = out_valid_q && !out_stall_i;

  // Gesture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // Output register and skid control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_pop) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
